### hw/rtl/spcm_pkg.sv
// Shared types, phrase table and intent lookup for the spoken command phrase matcher.
package spcm_pkg;

  localparam int unsigned PHRASE_COUNT = 9;
  localparam int unsigned TAIL_CHARS   = 11;
  localparam int unsigned TAIL_W       = 8 * TAIL_CHARS;
  localparam int unsigned LEN_W        = 6;

  typedef enum logic [3:0] {
    INTENT_NONE        = 4'd0,
    INTENT_GO_FORWARD  = 4'd1,
    INTENT_GO_BACKWARD = 4'd2,
    INTENT_TURN_LEFT   = 4'd3,
    INTENT_TURN_RIGHT  = 4'd4,
    INTENT_LOOK_LEFT   = 4'd5,
    INTENT_LOOK_RIGHT  = 4'd6,
    INTENT_STOP        = 4'd7,
    INTENT_COME_HERE   = 4'd8,
    INTENT_CANCEL      = 4'd9
  } intent_t;

  typedef struct packed {
    logic       shift;
    logic       two;
    logic [7:0] ch;
  } shift_ctl_t;

  // Last character of each phrase sits in the low byte, matching the newest cell.
  localparam logic [TAIL_W-1:0] PHRASE_TEXT [PHRASE_COUNT] = '{
    "go forward", "go backward", "turn left", "turn right", "look left",
    "look right", "stop", "come here", "cancel"
  };

  localparam int unsigned PHRASE_LEN [PHRASE_COUNT] = '{10, 11, 9, 10, 9, 10, 4, 9, 6};

  function automatic intent_t match_intent(input logic [TAIL_W-1:0] tail,
                                           input logic [LEN_W-1:0]  len);
    intent_t code;
    logic    hit;
    code = INTENT_NONE;
    for (int p = PHRASE_COUNT - 1; p >= 0; p--) begin
      hit = (len == LEN_W'(PHRASE_LEN[p]));
      for (int j = 0; j < TAIL_CHARS; j++) begin
        if (j < PHRASE_LEN[p] && tail[8*j +: 8] != PHRASE_TEXT[p][8*j +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        code = intent_t'(4'(p + 1));
      end
    end
    return code;
  endfunction

endpackage

### hw/rtl/spcm_if.sv
// Valid/ready channel interfaces for transcript bytes and intent results.
interface spcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       byte_present;
  logic       end_of_text;

  modport source (output valid, output text_byte, output byte_present, output end_of_text,
                  input ready);
  modport sink (input valid, input text_byte, input byte_present, input end_of_text,
                output ready);
endinterface

interface spcm_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] intent_code;
  logic       has_match;

  modport source (output valid, output intent_code, output has_match, input ready);
  modport sink (input valid, input intent_code, input has_match, output ready);
endinterface

### hw/rtl/spoken_command_phrase_matcher_core.sv
// Top level: normalizer front, character cell chain, phrase compare and result register.
//
//   channel  | dir | payload                              | when it moves
//   in_ch    | in  | text_byte, byte_present, end_of_text | valid && ready
//   out_ch   | out | intent_code, has_match               | valid && ready, one per end_of_text
//
// One item per cycle while in_ch.ready is high. The newest character enters cell 0 and
// older ones move one cell along (two when a pending space goes in with it). An end_of_text
// item is compared in its own cycle and its result appears in the output register on the
// next edge. in_ch.ready is low only while a result waits and out_ch.ready is low.
// Reset is synchronous; it clears the length and flags, cell contents need no reset.
module spoken_command_phrase_matcher_core #(
  parameter int unsigned MAX_TEXT_LEN = 12
) (
  input  logic           clk,
  input  logic           rst_n,
  spcm_in_if.sink        in_ch,
  spcm_out_if.source     out_ch
);

  spcm_pkg::shift_ctl_t           ctl;
  logic [spcm_pkg::LEN_W-1:0]     len_upd;
  logic                           bad_upd;
  logic                           take;
  logic [7:0]                     cell_nxt [MAX_TEXT_LEN];
  logic [7:0]                     cell_r   [MAX_TEXT_LEN];
  logic [spcm_pkg::TAIL_W-1:0]    tail;
  spcm_pkg::intent_t              intent;
  logic                           out_valid_r, out_valid_nxt;
  spcm_pkg::intent_t              out_intent_r, out_intent_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  spcm_front #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .text_byte    (in_ch.text_byte),
    .byte_present (in_ch.byte_present),
    .end_of_text  (in_ch.end_of_text),
    .ctl          (ctl),
    .len_upd      (len_upd),
    .bad_upd      (bad_upd)
  );

  for (genvar i = 0; i < MAX_TEXT_LEN; i++) begin : g_cell
    logic [7:0] one, two;
    if (i == 0) begin : g_head
      assign one = ctl.ch;
      assign two = ctl.ch;
    end else if (i == 1) begin : g_second
      assign one = cell_r[0];
      assign two = 8'h20;
    end else begin : g_body
      assign one = cell_r[i-1];
      assign two = cell_r[i-2];
    end
    spcm_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .from_one (one),
      .from_two (two),
      .q_nxt    (cell_nxt[i]),
      .q_r      (cell_r[i])
    );
  end

  for (genvar j = 0; j < spcm_pkg::TAIL_CHARS; j++) begin : g_tail
    assign tail[8*j +: 8] = cell_nxt[j];
  end

  always_comb begin
    intent = spcm_pkg::match_intent(tail, len_upd);
    if (bad_upd) begin
      intent = spcm_pkg::INTENT_NONE;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_intent_nxt = out_intent_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take && in_ch.end_of_text) begin
      out_valid_nxt  = 1'b1;
      out_intent_nxt = intent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_intent_r <= out_intent_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.intent_code = out_intent_r;
  assign out_ch.has_match   = out_intent_r != spcm_pkg::INTENT_NONE;

endmodule

### hw/rtl/spcm_cell.sv
// One character cell of the text chain, loading from one or two places back.
module spcm_cell (
  input  logic                  clk,
  input  spcm_pkg::shift_ctl_t  ctl,
  input  logic [7:0]            from_one,
  input  logic [7:0]            from_two,
  output logic [7:0]            q_nxt,
  output logic [7:0]            q_r
);

  always_comb begin
    q_nxt = q_r;
    if (ctl.shift) begin
      q_nxt = ctl.two ? from_two : from_one;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

### hw/rtl/spcm_front.sv
// Byte classifier and normalizer state: spacing, punctuation, length and overflow.
module spcm_front #(
  parameter int unsigned MAX_TEXT_LEN = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [7:0]                    text_byte,
  input  logic                          byte_present,
  input  logic                          end_of_text,
  output spcm_pkg::shift_ctl_t          ctl,
  output logic [spcm_pkg::LEN_W-1:0]    len_upd,
  output logic                          bad_upd
);

  localparam int unsigned LW = $clog2(MAX_TEXT_LEN + 1);
  localparam int unsigned SW = LW + 1;

  logic [LW-1:0] len_r, len_nxt, len_new;
  logic [SW-1:0] len_sum;
  logic          ovf_r, ovf_nxt, ovf_new;
  logic          inner_r, inner_nxt, inner_new;
  logic          punct_r, punct_nxt, punct_new;
  logic          space_r, space_nxt, space_new;
  logic          seen_r, seen_nxt, seen_new;
  logic          blank, mark, upper;

  assign blank = text_byte == 8'h20 || text_byte == 8'h09 || text_byte == 8'h0a ||
                 text_byte == 8'h0b || text_byte == 8'h0c || text_byte == 8'h0d;
  assign mark  = text_byte == 8'h2e || text_byte == 8'h2c || text_byte == 8'h21 ||
                 text_byte == 8'h3f || text_byte == 8'h3b || text_byte == 8'h3a;
  assign upper = text_byte >= 8'h41 && text_byte <= 8'h5a;
  assign len_sum = {1'b0, len_r} + (space_r ? SW'(2) : SW'(1));

  always_comb begin
    len_new   = len_r;
    ovf_new   = ovf_r;
    inner_new = inner_r;
    punct_new = punct_r;
    space_new = space_r;
    seen_new  = seen_r;
    ctl       = '0;
    ctl.ch    = upper ? text_byte + 8'h20 : text_byte;
    ctl.two   = space_r;
    if (take && byte_present) begin
      if (blank) begin
        if (seen_r) begin
          space_new = 1'b1;
        end
      end else begin
        seen_new  = 1'b1;
        space_new = 1'b0;
        if (mark) begin
          if (punct_r) begin
            if (space_r) begin
              inner_new = 1'b1;
            end
          end else begin
            punct_new = 1'b1;
          end
        end else if (punct_r) begin
          inner_new = 1'b1;
        end else begin
          ctl.shift = 1'b1;
          if (len_sum > SW'(MAX_TEXT_LEN)) begin
            ovf_new = 1'b1;
            len_new = LW'(MAX_TEXT_LEN);
          end else begin
            len_new = len_sum[LW-1:0];
          end
        end
      end
    end
    len_upd = spcm_pkg::LEN_W'(len_new);
    bad_upd = ovf_new || inner_new;
  end

  always_comb begin
    len_nxt   = len_new;
    ovf_nxt   = ovf_new;
    inner_nxt = inner_new;
    punct_nxt = punct_new;
    space_nxt = space_new;
    seen_nxt  = seen_new;
    if (take && end_of_text) begin
      len_nxt   = '0;
      ovf_nxt   = 1'b0;
      inner_nxt = 1'b0;
      punct_nxt = 1'b0;
      space_nxt = 1'b0;
      seen_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      ovf_r   <= 1'b0;
      inner_r <= 1'b0;
      punct_r <= 1'b0;
      space_r <= 1'b0;
      seen_r  <= 1'b0;
    end else begin
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      inner_r <= inner_nxt;
      punct_r <= punct_nxt;
      space_r <= space_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

### hw/rtl/spcm_checker.sv
// Port-level assertions for the phrase matcher, bound to the top level.
module spcm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_intent,
  input logic       out_match
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_intent) && $stable(out_match))
    else $error("result changed while stalled");

  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_match == (out_intent != spcm_pkg::INTENT_NONE)) &&
                  out_intent <= spcm_pkg::INTENT_CANCEL)
    else $error("intent code and match flag disagree");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end |=> out_valid)
    else $error("end of text gave no result");

  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && in_ready && !in_end |=> !out_valid)
    else $error("result without end of text");

  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind spoken_command_phrase_matcher_core spcm_checker u_spcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_end     (in_ch.end_of_text),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_intent (out_ch.intent_code),
  .out_match  (out_ch.has_match)
);
